// File: design/hmlt_pkg.sv
// hmlt_pkg: shared types, constants and the annex a limit tables for the
// level and tier search. no dependencies; used by every module of the block.
package hmlt_pkg;

  localparam int LEVEL_COUNT_DEF = 13;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DIV_STEPS       = 64;

  localparam logic [10:0] NAL_FACTOR      = 11'd1100;
  localparam logic [12:0] CPB_SCALE       = 13'd8000;
  localparam logic [9:0]  BR_SCALE        = 10'd1000;
  localparam logic [4:0]  DPB_MIN         = 5'd6;
  localparam logic [4:0]  DPB_MAX         = 5'd16;
  localparam logic [25:0] MAX_PS_TOP      = 26'd35651584;
  localparam logic [31:0] MAX_SR_TOP      = 32'd4278190080;
  localparam logic [3:0]  FIRST_HIGH_TIER = 4'd5;
  localparam logic [32:0] SR_SATURATED    = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL1, F_MUL2, F_DIV, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_SEARCH, B_DONE
  } back_state_t;

  // classified stream description as it waits for the search
  typedef struct packed {
    logic [31:0] pic;
    logic [31:0] ww;
    logic [31:0] hh;
    logic [32:0] sr;
    logic [15:0] refs;
    logic [5:0]  tcols;
    logic [5:0]  trows;
    logic [15:0] slices;
    logic [34:0] buf_x;
    logic [31:0] kbps_x;
    logic [3:0]  lvl;
    logic        tier;
    logic        invalid;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } front_out_t;

  typedef struct packed {
    logic avail;
    job_t job;
  } queue_head_t;

  function automatic logic [25:0] lim_max_ps(input logic [3:0] lvl);
    logic [25:0] v;
    case (lvl)
      4'd0:                   v = 26'd36864;
      4'd1:                   v = 26'd122880;
      4'd2:                   v = 26'd245760;
      4'd3:                   v = 26'd552960;
      4'd4:                   v = 26'd983040;
      4'd5, 4'd6:             v = 26'd2228224;
      4'd7, 4'd8, 4'd9:       v = 26'd8912896;
      default:                v = MAX_PS_TOP;
    endcase
    return v;
  endfunction

  function automatic logic [19:0] lim_cpb(input logic [3:0] lvl, input logic tier);
    logic [19:0] v;
    case (lvl)
      4'd0:    v = 20'd350;
      4'd1:    v = 20'd1500;
      4'd2:    v = 20'd3000;
      4'd3:    v = 20'd6000;
      4'd4:    v = 20'd10000;
      4'd5:    v = tier ? 20'd30000  : 20'd12000;
      4'd6:    v = tier ? 20'd50000  : 20'd20000;
      4'd7:    v = tier ? 20'd100000 : 20'd25000;
      4'd8:    v = tier ? 20'd160000 : 20'd40000;
      4'd9:    v = tier ? 20'd240000 : 20'd60000;
      4'd10:   v = tier ? 20'd240000 : 20'd60000;
      4'd11:   v = tier ? 20'd480000 : 20'd120000;
      default: v = tier ? 20'd800000 : 20'd240000;
    endcase
    return v;
  endfunction

  function automatic logic [19:0] lim_br(input logic [3:0] lvl, input logic tier);
    logic [19:0] v;
    case (lvl)
      4'd0:    v = 20'd128;
      4'd1:    v = 20'd1500;
      4'd2:    v = 20'd3000;
      4'd3:    v = 20'd6000;
      4'd4:    v = 20'd10000;
      4'd5:    v = tier ? 20'd30000  : 20'd12000;
      4'd6:    v = tier ? 20'd50000  : 20'd20000;
      4'd7:    v = tier ? 20'd100000 : 20'd25000;
      4'd8:    v = tier ? 20'd160000 : 20'd40000;
      4'd9:    v = tier ? 20'd240000 : 20'd60000;
      4'd10:   v = tier ? 20'd240000 : 20'd60000;
      4'd11:   v = tier ? 20'd480000 : 20'd120000;
      default: v = tier ? 20'd800000 : 20'd240000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] lim_sr(input logic [3:0] lvl);
    logic [31:0] v;
    case (lvl)
      4'd0:        v = 32'd552960;
      4'd1:        v = 32'd3686400;
      4'd2:        v = 32'd7372800;
      4'd3:        v = 32'd16588800;
      4'd4:        v = 32'd33177600;
      4'd5:        v = 32'd66846720;
      4'd6:        v = 32'd133693440;
      4'd7:        v = 32'd267386880;
      4'd8:        v = 32'd534773760;
      4'd9, 4'd10: v = 32'd1069547520;
      4'd11:       v = 32'd2139095040;
      default:     v = MAX_SR_TOP;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] lim_slices(input logic [3:0] lvl);
    logic [9:0] v;
    case (lvl)
      4'd0, 4'd1:       v = 10'd16;
      4'd2:             v = 10'd20;
      4'd3:             v = 10'd30;
      4'd4:             v = 10'd40;
      4'd5, 4'd6:       v = 10'd75;
      4'd7, 4'd8, 4'd9: v = 10'd200;
      default:          v = 10'd600;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] lim_tile_rows(input logic [3:0] lvl);
    logic [4:0] v;
    case (lvl)
      4'd0, 4'd1, 4'd2: v = 5'd1;
      4'd3:             v = 5'd2;
      4'd4:             v = 5'd3;
      4'd5, 4'd6:       v = 5'd5;
      4'd7, 4'd8, 4'd9: v = 5'd11;
      default:          v = 5'd22;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] lim_tile_cols(input logic [3:0] lvl);
    logic [4:0] v;
    case (lvl)
      4'd0, 4'd1, 4'd2: v = 5'd1;
      4'd3:             v = 5'd2;
      4'd4:             v = 5'd3;
      4'd5, 4'd6:       v = 5'd5;
      4'd7, 4'd8, 4'd9: v = 5'd10;
      default:          v = 5'd20;
    endcase
    return v;
  endfunction

  // dpb size in pictures for a given picture size
  function automatic logic [4:0] dpb_limit(input logic [31:0] pic, input logic [25:0] max_ps);
    logic [27:0] three_q;
    logic [4:0]  v;
    three_q = {2'b00, max_ps} + {1'b0, max_ps, 1'b0};
    if (pic <= {8'd0, max_ps[25:2]})
      v = DPB_MAX;
    else if (pic <= {7'd0, max_ps[25:1]})
      v = 5'd12;
    else if (pic <= {6'd0, three_q[27:2]})
      v = 5'd8;
    else
      v = DPB_MIN;
    return v;
  endfunction

endpackage

// File: design/hmlt_front.sv
// hmlt_front: accepts stream descriptions, forms the picture products and the
// ceiling luma sample rate with a bit-serial divider. depends on hmlt_pkg.
module hmlt_front
  import hmlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_frame_rate_num,
  input  logic [31:0] in_frame_rate_den,
  input  logic [15:0] in_pic_width,
  input  logic [15:0] in_pic_height,
  input  logic [15:0] in_min_refs,
  input  logic [5:0]  in_tile_cols,
  input  logic [5:0]  in_tile_rows,
  input  logic [15:0] in_slice_count,
  input  logic [21:0] in_buffer_kbytes,
  input  logic [21:0] in_peak_kbps,
  input  logic [3:0]  in_start_level_index,
  input  logic        in_start_tier,
  input  logic        q_full,
  output front_out_t  fo
);

  localparam int CntW = $clog2(DIV_STEPS);

  front_state_t state_r, state_nxt;

  logic [31:0] num_r, num_nxt, den_r, den_nxt;
  logic [15:0] w_r, w_nxt, h_r, h_nxt;
  logic [21:0] buf_r, buf_nxt, kbps_r, kbps_nxt;
  logic [31:0] pic_r, pic_nxt, ww_r, ww_nxt, hh_r, hh_nxt;
  logic [34:0] buf_x_r, buf_x_nxt;
  logic [31:0] kbps_x_r, kbps_x_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [15:0] refs_r, refs_nxt, slices_r, slices_nxt;
  logic [5:0]  tcols_r, tcols_nxt, trows_r, trows_nxt;
  logic [3:0]  lvl_r, lvl_nxt;
  logic        tier_r, tier_nxt, inv_r, inv_nxt;

  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_diff;
  logic        round_up;
  logic [32:0] sr_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    buf_r    <= buf_nxt;
    kbps_r   <= kbps_nxt;
    pic_r    <= pic_nxt;
    ww_r     <= ww_nxt;
    hh_r     <= hh_nxt;
    buf_x_r  <= buf_x_nxt;
    kbps_x_r <= kbps_x_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    refs_r   <= refs_nxt;
    slices_r <= slices_nxt;
    tcols_r  <= tcols_nxt;
    trows_r  <= trows_nxt;
    lvl_r    <= lvl_nxt;
    tier_r   <= tier_nxt;
    inv_r    <= inv_nxt;
  end

  // one restoring division step per cycle; quotient bits shift into prod_r
  assign rem_sh   = {rem_r, prod_r[63]};
  assign ge       = rem_sh >= {1'b0, den_r};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign round_up = rem_r != 32'd0;
  assign sr_sat   = (prod_r[63:32] != 32'd0) ? SR_SATURATED
                                             : ({1'b0, prod_r[31:0]} + {32'd0, round_up});

  always_comb begin
    state_nxt  = state_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    buf_nxt    = buf_r;
    kbps_nxt   = kbps_r;
    pic_nxt    = pic_r;
    ww_nxt     = ww_r;
    hh_nxt     = hh_r;
    buf_x_nxt  = buf_x_r;
    kbps_x_nxt = kbps_x_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    refs_nxt   = refs_r;
    slices_nxt = slices_r;
    tcols_nxt  = tcols_r;
    trows_nxt  = trows_r;
    lvl_nxt    = lvl_r;
    tier_nxt   = tier_r;
    inv_nxt    = inv_r;
    in_stall   = 1'b1;
    fo.push    = 1'b0;

    case (state_r)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          num_nxt    = in_frame_rate_num;
          den_nxt    = in_frame_rate_den;
          w_nxt      = in_pic_width;
          h_nxt      = in_pic_height;
          buf_nxt    = in_buffer_kbytes;
          kbps_nxt   = in_peak_kbps;
          refs_nxt   = in_min_refs;
          slices_nxt = in_slice_count;
          tcols_nxt  = in_tile_cols;
          trows_nxt  = in_tile_rows;
          lvl_nxt    = in_start_level_index;
          tier_nxt   = in_start_tier;
          inv_nxt    = (in_frame_rate_num == 32'd0) || (in_frame_rate_den == 32'd0);
          state_nxt  = inv_nxt ? F_PUSH : F_MUL1;
        end
      end
      F_MUL1: begin
        pic_nxt    = w_r * h_r;
        ww_nxt     = w_r * w_r;
        hh_nxt     = h_r * h_r;
        buf_x_nxt  = buf_r * CPB_SCALE;
        kbps_x_nxt = kbps_r * BR_SCALE;
        state_nxt  = F_MUL2;
      end
      F_MUL2: begin
        prod_nxt  = pic_r * num_r;
        rem_nxt   = 32'd0;
        cnt_nxt   = '0;
        state_nxt = F_DIV;
      end
      F_DIV: begin
        rem_nxt  = ge ? rem_diff[31:0] : rem_sh[31:0];
        prod_nxt = {prod_r[62:0], ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CntW'(DIV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          fo.push   = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  assign fo.job.pic     = pic_r;
  assign fo.job.ww      = ww_r;
  assign fo.job.hh      = hh_r;
  assign fo.job.sr      = sr_sat;
  assign fo.job.refs    = refs_r;
  assign fo.job.tcols   = tcols_r;
  assign fo.job.trows   = trows_r;
  assign fo.job.slices  = slices_r;
  assign fo.job.buf_x   = buf_x_r;
  assign fo.job.kbps_x  = kbps_x_r;
  assign fo.job.lvl     = lvl_r;
  assign fo.job.tier    = tier_r;
  assign fo.job.invalid = inv_r;

endmodule

// File: design/hmlt_queue.sv
// hmlt_queue: short queue of classified jobs between the front end and the
// search engine. depends on hmlt_pkg.
module hmlt_queue
  import hmlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  front_out_t  fo,
  input  logic        pop,
  output logic        q_full,
  output queue_head_t head
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_full     = cnt_r == CntW'(QUEUE_DEPTH);
  assign head.avail = cnt_r != '0;
  assign head.job   = mem_r[rd_r];
  assign do_push    = fo.push && !q_full;
  assign do_pop     = pop && head.avail;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= fo.job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    fo.push |-> !q_full)
    else $error("front end pushed into a full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.avail && !fo.push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("pop did not lower the fill count");

endmodule

// File: design/hmlt_back.sv
// hmlt_back: walks the level and tier tables one step per cycle for the job
// at the queue head and holds the result in the output register. depends on hmlt_pkg.
module hmlt_back
  import hmlt_pkg::*;
#(
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_level_index,
  output logic        out_high_tier,
  output logic        out_rate_invalid
);

  localparam logic [3:0] LvlTop = 4'(LEVEL_COUNT - 1);

  back_state_t state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [3:0]  lvl_r, lvl_nxt;
  logic        tier_r, tier_nxt;
  logic [3:0]  res_lvl_r, res_lvl_nxt;
  logic        res_tier_r, res_tier_nxt, res_inv_r, res_inv_nxt;
  logic        ov_r, ov_nxt;
  logic [3:0]  olvl_r, olvl_nxt;
  logic        otier_r, otier_nxt, oinv_r, oinv_nxt;

  logic [25:0] max_ps;
  logic [31:0] max_ps8;
  logic [29:0] cpb_nal, br_nal;
  logic        next_tier, max_tier, next_level, go;
  logic [3:0]  step_lvl;
  logic        step_tier;

  // one search step on the current level and tier
  always_comb begin
    max_ps   = lim_max_ps(lvl_r);
    max_ps8  = {3'b000, max_ps, 3'b000};
    cpb_nal  = {10'd0, lim_cpb(lvl_r, tier_r)} * {19'd0, NAL_FACTOR};
    br_nal   = {10'd0, lim_br(lvl_r, tier_r)} * {19'd0, NAL_FACTOR};

    next_tier = (job_r.buf_x > {5'd0, cpb_nal})
             || (job_r.sr > {1'b0, lim_sr(lvl_r)})
             || (job_r.kbps_x > {2'b00, br_nal});
    max_tier  = next_tier && (tier_r || (lvl_r < FIRST_HIGH_TIER));

    next_level = (job_r.pic > {6'd0, max_ps})
              || (job_r.ww > max_ps8)
              || (job_r.hh > max_ps8)
              || (job_r.refs >= {11'd0, dpb_limit(job_r.pic, max_ps)})
              || (job_r.tcols > {1'b0, lim_tile_cols(lvl_r)})
              || (job_r.trows > {1'b0, lim_tile_rows(lvl_r)})
              || (job_r.slices > {6'd0, lim_slices(lvl_r)})
              || max_tier;

    if (max_tier) begin
      step_tier = 1'b0;
    end else if (next_tier && !next_level) begin
      step_tier = 1'b1;
    end else begin
      step_tier = tier_r;
    end
    step_lvl = lvl_r + {3'd0, next_level};
    go       = (step_lvl <= LvlTop) && (next_tier || next_level);
  end

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    lvl_nxt      = lvl_r;
    tier_nxt     = tier_r;
    res_lvl_nxt  = res_lvl_r;
    res_tier_nxt = res_tier_r;
    res_inv_nxt  = res_inv_r;
    ov_nxt       = ov_r && out_stall;
    olvl_nxt     = olvl_r;
    otier_nxt    = otier_r;
    oinv_nxt     = oinv_r;
    pop          = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (head.avail) begin
          pop      = 1'b1;
          job_nxt  = head.job;
          lvl_nxt  = (head.job.lvl > LvlTop) ? LvlTop : head.job.lvl;
          tier_nxt = head.job.tier;
          if (head.job.invalid) begin
            res_lvl_nxt  = 4'd0;
            res_tier_nxt = 1'b0;
            res_inv_nxt  = 1'b1;
            state_nxt    = B_DONE;
          end else begin
            state_nxt = B_SEARCH;
          end
        end
      end
      B_SEARCH: begin
        lvl_nxt  = step_lvl;
        tier_nxt = step_tier;
        if (!go) begin
          // search finished, or ran past the last level: clamp
          res_lvl_nxt  = (step_lvl > LvlTop) ? LvlTop : step_lvl;
          res_tier_nxt = step_tier;
          res_inv_nxt  = 1'b0;
          state_nxt    = B_DONE;
        end
      end
      B_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          olvl_nxt  = res_lvl_r;
          otier_nxt = res_tier_r;
          oinv_nxt  = res_inv_r;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    lvl_r      <= lvl_nxt;
    tier_r     <= tier_nxt;
    res_lvl_r  <= res_lvl_nxt;
    res_tier_r <= res_tier_nxt;
    res_inv_r  <= res_inv_nxt;
    olvl_r     <= olvl_nxt;
    otier_r    <= otier_nxt;
    oinv_r     <= oinv_nxt;
  end

  assign out_valid        = ov_r;
  assign out_level_index  = olvl_r;
  assign out_high_tier    = otier_r;
  assign out_rate_invalid = oinv_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oinv_r) |-> (olvl_r == 4'd0 && !otier_r))
    else $error("invalid result carries a level or tier");

  a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> olvl_r <= LvlTop)
    else $error("result level beyond last level");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SEARCH) |-> lvl_r <= LvlTop)
    else $error("search stepped on a level past the table");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE && head.avail))
    else $error("queue popped outside idle");

endmodule

// File: design/hevc_min_level_tier_search.sv
// channel  | direction | handshake              | payload
// in_      | input     | in_valid / in_stall    | stream description, 12 fields
// out_     | output    | out_valid / out_stall  | level_index, high_tier, rate_invalid
//
// front end: the multiplies (F_MUL1, F_MUL2), a 64-step bit-serial divider for the ceiling
// luma sample rate, one push; it takes a new item only after pushing the last one.
// search engine: pop, 1 to 21 table steps, output load; one step a cycle.
// a zero frame rate term skips the divider and the search.
// reset is synchronous, active low; no clearing pass. a two-entry queue and the output
// register let either side stall without stopping the other.
module hevc_min_level_tier_search
  import hmlt_pkg::*;
#(
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_frame_rate_num,
  input  logic [31:0] in_frame_rate_den,
  input  logic [15:0] in_pic_width,
  input  logic [15:0] in_pic_height,
  input  logic [15:0] in_min_refs,
  input  logic [5:0]  in_tile_cols,
  input  logic [5:0]  in_tile_rows,
  input  logic [15:0] in_slice_count,
  input  logic [21:0] in_buffer_kbytes,
  input  logic [21:0] in_peak_kbps,
  input  logic [3:0]  in_start_level_index,
  input  logic        in_start_tier,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_level_index,
  output logic        out_high_tier,
  output logic        out_rate_invalid
);

  front_out_t  fo;
  queue_head_t head;
  logic        q_full;
  logic        pop;

  hmlt_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_frame_rate_num    (in_frame_rate_num),
    .in_frame_rate_den    (in_frame_rate_den),
    .in_pic_width         (in_pic_width),
    .in_pic_height        (in_pic_height),
    .in_min_refs          (in_min_refs),
    .in_tile_cols         (in_tile_cols),
    .in_tile_rows         (in_tile_rows),
    .in_slice_count       (in_slice_count),
    .in_buffer_kbytes     (in_buffer_kbytes),
    .in_peak_kbps         (in_peak_kbps),
    .in_start_level_index (in_start_level_index),
    .in_start_tier        (in_start_tier),
    .q_full               (q_full),
    .fo                   (fo)
  );

  hmlt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .fo     (fo),
    .pop    (pop),
    .q_full (q_full),
    .head   (head)
  );

  hmlt_back #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_index  (out_level_index),
    .out_high_tier    (out_high_tier),
    .out_rate_invalid (out_rate_invalid)
  );

endmodule
